[rtl/core/assert_macros.svh]
// Assertion macros shared by the queue RTL.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("invariant violated");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/fbk_pkg.sv]
// Types, constants and helpers for the removable-entry queue.
// No dependencies; used by fbk_seq and the top level.
package fbk_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam int OPC_W  = 2;
    localparam int DESC_W = 16;
    localparam int SEC_W  = 32;
    localparam int USEC_W = 20;
    localparam int POS_W  = 6;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OPC_W-1:0] {
        OP_ENQUEUE         = 2'd0,
        OP_POP             = 2'd1,
        OP_REMOVE_VALUE    = 2'd2,
        OP_REMOVE_POSITION = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_NONE    = 2'd1,
        STAT_DROPPED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } seq_state_t;

    // first member sits in the upper bits
    typedef struct packed {
        logic [USEC_W-1:0] usec;
        logic [SEC_W-1:0]  sec;
        logic [DESC_W-1:0] desc;
    } entry_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [USEC_W-1:0] arrival_usec;
        logic [SEC_W-1:0]  arrival_sec;
        logic [DESC_W-1:0] descriptor;
        op_t               opcode;
    } req_t;

    typedef struct packed {
        logic [OCC_W-1:0]  occupancy;
        logic [USEC_W-1:0] out_usec;
        logic [SEC_W-1:0]  out_sec;
        logic [DESC_W-1:0] out_descriptor;
        status_t           status;
    } res_t;

    localparam int ENTRY_W   = $bits(entry_t);
    localparam int REQ_W     = $bits(req_t);
    localparam int RES_W     = $bits(res_t);
    localparam int S_TDATA_W = ((REQ_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    // physical slot of the entry at offset off from the head (off < 2*depth)
    function automatic logic [PTR_W-1:0] slot_addr(input logic [PTR_W-1:0] head,
                                                   input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

[rtl/core/fbk_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fbk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/fbk_seq.sv]
// Queue sequencer: circular buffer in fbk_ram, head pointer and count,
// scan and shift-down walks one RAM access per cycle. Uses fbk_pkg, fbk_ram.
`include "assert_macros.svh"
module fbk_seq
    import fbk_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  req_t req,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    seq_state_t       state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [DESC_W-1:0] key_reg, key_next;
    status_t          status_reg, status_next;
    entry_t           taken_reg, taken_next;

    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr, ram_raddr;
    entry_t           ram_wdata, ram_rdata;

    logic             take;
    logic [CNT_W-1:0] idx_inc, idx_inc2;

    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_inc2 = idx_reg + CNT_W'(2);

    fbk_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        taken_reg  <= taken_next;
    end

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        status_next = status_reg;
        taken_next  = taken_reg;
        ram_we      = 1'b0;
        ram_waddr   = slot_addr(head_reg, idx_reg);
        ram_wdata   = ram_rdata;
        ram_raddr   = slot_addr(head_reg, idx_inc);
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        take        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    key_next    = req.descriptor;
                    status_next = STAT_NONE;
                    taken_next  = '0;
                    state_next  = S_RESULT;
                    case (req.opcode)
                        OP_ENQUEUE: begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                                status_next = STAT_DROPPED;
                            end else begin
                                ram_we      = 1'b1;
                                ram_waddr   = slot_addr(head_reg, count_reg);
                                ram_wdata   = '{usec: req.arrival_usec,
                                                sec:  req.arrival_sec,
                                                desc: req.descriptor};
                                count_next  = count_reg + CNT_W'(1);
                                status_next = STAT_DONE;
                            end
                        end
                        OP_POP: begin
                            if (count_reg != '0) begin
                                idx_next   = '0;
                                ram_raddr  = head_reg;
                                state_next = S_FETCH;
                            end
                        end
                        OP_REMOVE_VALUE: begin
                            if (count_reg != '0) begin
                                idx_next   = '0;
                                ram_raddr  = head_reg;
                                state_next = S_SCAN;
                            end
                        end
                        OP_REMOVE_POSITION: begin
                            if (CMP_W'(req.position) < CMP_W'(count_reg)) begin
                                idx_next   = CNT_W'(req.position);
                                ram_raddr  = slot_addr(head_reg, CNT_W'(req.position));
                                state_next = S_FETCH;
                            end
                        end
                        default: begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                take = 1'b1;
            end
            S_SCAN: begin
                // data for idx_reg lands now; the read of idx_reg+1 goes out
                if (ram_rdata.desc == key_reg) begin
                    take = 1'b1;
                end else if (idx_inc == count_reg) begin
                    state_next = S_RESULT;
                end else begin
                    idx_next = idx_inc;
                end
            end
            S_SHIFT: begin
                // entry idx_reg+1 lands, written one slot toward the head
                ram_we = 1'b1;
                if (idx_inc2 == count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RESULT;
                end else begin
                    idx_next  = idx_inc;
                    ram_raddr = slot_addr(head_reg, idx_inc2);
                end
            end
            S_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (take) begin
            taken_next  = ram_rdata;
            status_next = STAT_DONE;
            if (idx_reg == '0) begin
                head_next  = slot_addr(head_reg, CNT_W'(1));
                count_next = count_reg - CNT_W'(1);
                state_next = S_RESULT;
            end else if (idx_inc == count_reg) begin
                count_next = count_reg - CNT_W'(1);
                state_next = S_RESULT;
            end else begin
                ram_raddr  = slot_addr(head_reg, idx_inc);
                state_next = S_SHIFT;
            end
        end
    end

    assign res = '{occupancy:      OCC_W'(count_reg),
                   out_usec:       taken_reg.usec,
                   out_sec:        taken_reg.sec,
                   out_descriptor: taken_reg.desc,
                   status:         status_reg};

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(QUEUE_DEPTH))
    `ASSERT_ALWAYS(a_head_bound, aclk, aresetn, PTR_W'(head_reg) <= PTR_W'(QUEUE_DEPTH - 1))
    `ASSERT_IMPLIES(a_no_rw_clash, aclk, aresetn, state_reg == S_SHIFT, ram_waddr != ram_raddr || idx_inc2 == count_reg)
    `ASSERT_NEXT(a_enq_grows, aclk, aresetn, state_reg == S_IDLE && in_valid && req.opcode == OP_ENQUEUE && count_reg != CNT_W'(QUEUE_DEPTH), count_reg == $past(count_reg) + CNT_W'(1))
    `ASSERT_NEXT(a_result_holds, aclk, aresetn, state_reg == S_RESULT, $stable(count_reg) && $stable(head_reg))

endmodule

[rtl/core/fifo_remove_by_key_or_index.sv]
// Queue with removal by descriptor or position; entries kept in a RAM ring.
// An enqueue, or a miss on position/empty, goes straight to the result state;
// a pop fetches the head entry first, and a scan or shift walk moves one RAM
// entry per cycle. Results pass through an output register; the next item is
// taken in the cycle after the result moves into it. Synchronous active-low
// reset empties the queue; stored entries are not cleared. Uses fbk_pkg and fbk_seq.
module fifo_remove_by_key_or_index
    import fbk_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // opcode, descriptor, arrival_sec, arrival_usec, position, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status, out_descriptor, out_sec, out_usec, occupancy, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    req_t req;
    res_t res;
    logic res_valid, res_ready;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign req = req_t'(s_tdata[REQ_W-1:0]);

    fbk_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .req      (req),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    // output register decouples the result side from the sequencer
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_tdata_reg <= M_TDATA_W'(res);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
